@@ hdl/led_matrix_pwm_scan_driver_assert.svh @@
// assertion macros for the led matrix scan driver checker
`ifndef LED_MATRIX_PWM_SCAN_DRIVER_ASSERT_SVH
`define LED_MATRIX_PWM_SCAN_DRIVER_ASSERT_SVH

// same-cycle implication, off while in reset
`define LMPSD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define LMPSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold on the cycle after a reset cycle
`define LMPSD_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lmpsd_pkg.sv @@
package lmpsd_pkg;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_t;

  localparam logic [3:0] DEPTH_BITS_RESET = 4'd8;
  localparam logic [3:0] DEPTH_BITS_MIN   = 4'd1;
  localparam logic [3:0] DEPTH_BITS_MAX   = 4'd8;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  // one queued command from the front to the back
  typedef struct packed {
    logic        is_write;
    logic        upper;
    logic [23:0] color;
    logic [7:0]  step;
    logic [3:0]  row_address;
    logic [5:0]  column;
    logic        latch;
    logic        frame_end;
  } cmd_t;

  typedef struct packed {
    logic [5:0] hub75_bits;
    logic [3:0] row_address;
    logic [5:0] shift_column;
    logic       latch;
    logic       frame_end;
  } result_t;

endpackage

@@ hdl/lmpsd_fifo.sv @@
module lmpsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

@@ hdl/lmpsd_front.sv @@
module lmpsd_front #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic                                 req_type,
  input  logic [4:0]                           pixel_row,
  input  logic [5:0]                           pixel_column,
  input  logic [23:0]                          pixel_color,
  input  logic                                 cfg_we,
  input  logic [3:0]                           cfg_wdata,
  output logic                                 cmd_push,
  output lmpsd_pkg::cmd_t                      cmd,
  output logic [$clog2((ROWS/2)*COLUMNS)-1:0]  cmd_addr
);
  import lmpsd_pkg::*;

  localparam int PAIRS      = ROWS / 2;
  localparam int BANK_DEPTH = PAIRS * COLUMNS;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int CW         = $clog2(COLUMNS);
  localparam int PW         = $clog2(PAIRS);
  localparam int RCW        = ($clog2(ROWS + 1) > 5) ? $clog2(ROWS + 1) : 5;
  localparam int CCW        = ($clog2(COLUMNS + 1) > 6) ? $clog2(COLUMNS + 1) : 6;

  logic [CW-1:0]  col_r, col_nxt;
  logic [7:0]     step_r, step_nxt;
  logic [PW-1:0]  pair_r, pair_nxt;
  logic [3:0]     depth_r;
  logic [3:0]     depth_eff;
  logic [7:0]     step_last;
  logic           last_col, last_step, last_pair;
  logic           is_tick, tick;
  logic [RCW-1:0] row_x, row_in_bank;
  logic [CCW-1:0] col_x;
  logic           upper, wr_ok;
  logic [AW-1:0]  wr_addr, rd_addr;

  // depth codes outside 1..8 act as the nearest end
  always_comb begin
    if (depth_r < DEPTH_BITS_MIN) begin
      depth_eff = DEPTH_BITS_MIN;
    end else if (depth_r > DEPTH_BITS_MAX) begin
      depth_eff = DEPTH_BITS_MAX;
    end else begin
      depth_eff = depth_r;
    end
  end

  assign step_last = 8'((9'd1 << depth_eff) - 9'd1);
  assign last_col  = (col_r == '0);
  assign last_step = (step_r >= step_last);
  assign last_pair = (pair_r == PW'(PAIRS - 1));
  assign is_tick   = (req_type == REQ_TICK);
  assign tick      = accept & is_tick;

  // pixel write classification: bank select and range check
  assign row_x       = RCW'(pixel_row);
  assign col_x       = CCW'(pixel_column);
  assign upper       = (row_x < RCW'(PAIRS));
  assign row_in_bank = upper ? row_x : row_x - RCW'(PAIRS);
  assign wr_ok       = (row_x < RCW'(ROWS)) && (col_x < CCW'(COLUMNS));
  assign wr_addr     = AW'(row_in_bank) * AW'(COLUMNS) + AW'(pixel_column);
  assign rd_addr     = AW'(pair_r) * AW'(COLUMNS) + AW'(col_r);

  assign cmd_push = accept & (is_tick | wr_ok);
  assign cmd_addr = is_tick ? rd_addr : wr_addr;

  always_comb begin
    cmd.is_write    = ~is_tick;
    cmd.upper       = upper;
    cmd.color       = pixel_color;
    cmd.step        = step_r;
    cmd.row_address = 4'(pair_r);
    cmd.column      = 6'(col_r);
    cmd.latch       = last_col;
    cmd.frame_end   = last_col & last_step & last_pair;
  end

  // scan order: columns high to low, then pwm steps, then row pairs
  always_comb begin
    col_nxt  = col_r;
    step_nxt = step_r;
    pair_nxt = pair_r;
    if (tick) begin
      if (!last_col) begin
        col_nxt = col_r - 1'b1;
      end else begin
        col_nxt = CW'(COLUMNS - 1);
        if (!last_step) begin
          step_nxt = step_r + 8'd1;
        end else begin
          step_nxt = '0;
          pair_nxt = last_pair ? '0 : pair_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= CW'(COLUMNS - 1);
      step_r  <= '0;
      pair_r  <= '0;
      depth_r <= DEPTH_BITS_RESET;
    end else begin
      col_r  <= col_nxt;
      step_r <= step_nxt;
      pair_r <= pair_nxt;
      if (cfg_we) begin
        depth_r <= cfg_wdata;
      end
    end
  end

endmodule

@@ hdl/lmpsd_back.sv @@
module lmpsd_back #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lmpsd_pkg::cmd_t                     cmd,
  input  logic [$clog2((ROWS/2)*COLUMNS)-1:0] cmd_addr,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  output logic                                clearing,
  output logic                                res_empty,
  input  logic                                res_pop,
  output lmpsd_pkg::result_t                  res
);
  import lmpsd_pkg::*;

  localparam int PAIRS      = ROWS / 2;
  localparam int BANK_DEPTH = PAIRS * COLUMNS;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int PEND_W     = $clog2(OUTQ_DEPTH + 1);
  localparam int RES_W      = $bits(result_t);

  // upper bank holds rows 0..PAIRS-1, lower bank the rest
  logic [23:0] mem_up [BANK_DEPTH];
  logic [23:0] mem_lo [BANK_DEPTH];

  logic              clearing_r;
  logic [AW-1:0]     clr_addr_r;
  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic              credit_ok, tick_pop, res_pop_acc;
  logic              we_up, we_lo;
  logic [AW-1:0]     wr_addr;
  logic [23:0]       wr_data;
  logic [23:0]       rd_up_r, rd_lo_r;
  logic              sb_valid_r;
  logic [7:0]        sb_step_r;
  logic [3:0]        sb_row_r;
  logic [5:0]        sb_col_r;
  logic              sb_latch_r, sb_fend_r;
  result_t           res_nxt;
  logic [RES_W-1:0]  res_bits;

  assign clearing = clearing_r;

  // ticks need room downstream for their result; writes never do
  assign credit_ok   = (pending_r < PEND_W'(OUTQ_DEPTH));
  assign cmd_pop     = ~cmd_empty & ~clearing_r & (cmd.is_write | credit_ok);
  assign tick_pop    = cmd_pop & ~cmd.is_write;
  assign res_pop_acc = res_pop & ~res_empty;
  assign pending_nxt = pending_r + PEND_W'(tick_pop) - PEND_W'(res_pop_acc);

  assign we_up   = clearing_r | (cmd_pop & cmd.is_write & cmd.upper);
  assign we_lo   = clearing_r | (cmd_pop & cmd.is_write & ~cmd.upper);
  assign wr_addr = clearing_r ? clr_addr_r : cmd_addr;
  assign wr_data = clearing_r ? 24'd0 : cmd.color;

  always_ff @(posedge clk) begin
    if (we_up) begin
      mem_up[wr_addr] <= wr_data;
    end
    rd_up_r <= mem_up[cmd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem_lo[wr_addr] <= wr_data;
    end
    rd_lo_r <= mem_lo[cmd_addr];
  end

  // clear sweep after reset, one entry of each bank per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      pending_r  <= '0;
      sb_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(BANK_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      pending_r  <= pending_nxt;
      sb_valid_r <= tick_pop;
    end
  end

  always_ff @(posedge clk) begin
    sb_step_r  <= cmd.step;
    sb_row_r   <= cmd.row_address;
    sb_col_r   <= cmd.column;
    sb_latch_r <= cmd.latch;
    sb_fend_r  <= cmd.frame_end;
  end

  // a channel is lit while its value is above the pwm step
  always_comb begin
    res_nxt.hub75_bits[0] = (rd_up_r[7:0]   > sb_step_r);
    res_nxt.hub75_bits[1] = (rd_lo_r[7:0]   > sb_step_r);
    res_nxt.hub75_bits[2] = (rd_up_r[15:8]  > sb_step_r);
    res_nxt.hub75_bits[3] = (rd_lo_r[15:8]  > sb_step_r);
    res_nxt.hub75_bits[4] = (rd_up_r[23:16] > sb_step_r);
    res_nxt.hub75_bits[5] = (rd_lo_r[23:16] > sb_step_r);
    res_nxt.row_address   = sb_row_r;
    res_nxt.shift_column  = sb_col_r;
    res_nxt.latch         = sb_latch_r;
    res_nxt.frame_end     = sb_fend_r;
  end

  lmpsd_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (sb_valid_r),
    .wdata (res_nxt),
    .full  (),
    .pop   (res_pop),
    .rdata (res_bits),
    .empty (res_empty)
  );

  assign res = result_t'(res_bits);

endmodule

@@ hdl/led_matrix_pwm_scan_driver.sv @@
// latency: a tick beat's result passes through the command queue, the registered frame-store read and the result queue
// throughput: one beat per cycle, pixel writes and ticks alike, while full is low; all beats share
//   the one command queue, and a tick also waits for room in the result queue
// reset: synchronous active low; afterwards the frame store is swept to black, one entry of each
//   bank at a time over all ROWS/2*COLUMNS addresses, with full held high; cfg writes still land
module led_matrix_pwm_scan_driver #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [4:0]  in_pixel_row,
  input  logic [5:0]  in_pixel_column,
  input  logic [23:0] in_pixel_color,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_hub75_bits,
  output logic [3:0]  out_row_address,
  output logic [5:0]  out_shift_column,
  output logic        out_latch,
  output logic        out_frame_end
);
  import lmpsd_pkg::*;

  localparam int AW    = $clog2((ROWS / 2) * COLUMNS);
  localparam int CMD_W = $bits(cmd_t) + AW;

  logic             accept;
  logic             cmd_push, cmdq_full, cmdq_empty, cmd_pop;
  cmd_t             front_cmd, back_cmd;
  logic [AW-1:0]    front_addr, back_addr;
  logic [CMD_W-1:0] cmdq_rdata;
  logic             clearing;
  logic             res_empty;
  result_t          res;

  assign full   = cmdq_full | clearing | ~rst_n;
  assign accept = push & ~full;

  lmpsd_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_req_type),
    .pixel_row    (in_pixel_row),
    .pixel_column (in_pixel_column),
    .pixel_color  (in_pixel_color),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_push     (cmd_push),
    .cmd          (front_cmd),
    .cmd_addr     (front_addr)
  );

  lmpsd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata ({front_cmd, front_addr}),
    .full  (cmdq_full),
    .pop   (cmd_pop),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty)
  );

  assign back_cmd  = cmd_t'(cmdq_rdata[CMD_W-1:AW]);
  assign back_addr = cmdq_rdata[AW-1:0];

  lmpsd_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_addr  (back_addr),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .res_empty (res_empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign empty            = res_empty | ~rst_n;
  assign out_hub75_bits   = res.hub75_bits;
  assign out_row_address  = res.row_address;
  assign out_shift_column = res.shift_column;
  assign out_latch        = res.latch;
  assign out_frame_end    = res.frame_end;

endmodule

@@ hdl/lmpsd_checker.sv @@
`include "led_matrix_pwm_scan_driver_assert.svh"

module lmpsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [5:0] out_hub75_bits,
  input logic [5:0] out_shift_column,
  input logic       out_latch,
  input logic       out_frame_end
);

  // latch only comes with column zero
  `LMPSD_ASSERT_IMPLIES(a_latch_col0, !empty && out_latch, out_shift_column == 6'd0, "latch off column 0")

  // frame end is always the last column of a row pair
  `LMPSD_ASSERT_IMPLIES(a_fend_latch, !empty && out_frame_end, out_latch, "frame end without latch")

  // reset leaves nothing to read and blocks input for the clear sweep
  `LMPSD_ASSERT_AFTER_RESET(a_reset_state, full && empty, "queue not blocked after reset")

  // a result beat that is not taken stays put
  `LMPSD_ASSERT_NEXT(a_hold_beat, !empty && !pop, !empty && $stable(out_hub75_bits), "beat lost")

endmodule

bind led_matrix_pwm_scan_driver lmpsd_checker u_lmpsd_checker (.*);

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmpsd_pkg::*;

  localparam int COLUMNS = 64;
  localparam int ROWS    = 32;
  localparam int PAIRS   = ROWS / 2;

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        push            = 1'b0;
  logic        full;
  logic        in_req_type     = REQ_PIXEL;
  logic [4:0]  in_pixel_row    = '0;
  logic [5:0]  in_pixel_column = '0;
  logic [23:0] in_pixel_color  = '0;
  logic        cfg_we          = 1'b0;
  logic [3:0]  cfg_wdata       = DEPTH_BITS_RESET;
  logic        empty;
  logic        pop             = 1'b0;
  logic [5:0]  out_hub75_bits;
  logic [3:0]  out_row_address;
  logic [5:0]  out_shift_column;
  logic        out_latch;
  logic        out_frame_end;

  led_matrix_pwm_scan_driver #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_column (in_pixel_column),
    .in_pixel_color  (in_pixel_color),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .empty           (empty),
    .pop             (pop),
    .out_hub75_bits  (out_hub75_bits),
    .out_row_address (out_row_address),
    .out_shift_column(out_shift_column),
    .out_latch       (out_latch),
    .out_frame_end   (out_frame_end)
  );

  // mirror of the frame store and the scan counters
  logic [23:0] frame_mirror [ROWS*COLUMNS];
  int unsigned scan_col;
  int unsigned scan_step;
  int unsigned scan_pair;
  logic [3:0]  depth_reg;
  result_t     pending_columns[$];

  int error_count     = 0;
  int beats_sent      = 0;
  int columns_checked = 0;
  int frames_seen     = 0;
  int burst_left      = 0;
  bit sender_idle_on  = 1'b1;
  bit hold_request    = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // {blue, green, red} lit for one pixel at one pwm step
  function automatic logic [2:0] channels_over(logic [23:0] px, int unsigned step);
    channels_over = {int'(px[23:16]) > step, int'(px[15:8]) > step, int'(px[7:0]) > step};
  endfunction

  function automatic result_t advance_scan();
    result_t     r;
    int unsigned eff;
    int unsigned steps;
    logic [2:0]  up;
    logic [2:0]  lo;
    bit          last_step;
    bit          last_pair;
    eff = (depth_reg < DEPTH_BITS_MIN) ? DEPTH_BITS_MIN :
          (depth_reg > DEPTH_BITS_MAX) ? DEPTH_BITS_MAX : depth_reg;
    steps = 1 << eff;
    if (scan_col >= COLUMNS) scan_col = COLUMNS - 1;
    if (scan_pair >= PAIRS) scan_pair = 0;
    scan_step &= 8'hFF;
    up = channels_over(frame_mirror[scan_pair*COLUMNS + scan_col], scan_step);
    lo = channels_over(frame_mirror[(PAIRS + scan_pair)*COLUMNS + scan_col], scan_step);
    r.hub75_bits   = {lo[2], up[2], lo[1], up[1], lo[0], up[0]};
    r.row_address  = 4'(scan_pair);
    r.shift_column = 6'(scan_col);
    r.latch        = (scan_col == 0);
    last_step      = (scan_step + 1 >= steps);
    last_pair      = (scan_pair + 1 >= PAIRS);
    r.frame_end    = r.latch && last_step && last_pair;
    if (!r.latch) begin
      scan_col = scan_col - 1;
    end else begin
      scan_col = COLUMNS - 1;
      if (!last_step) begin
        scan_step = scan_step + 1;
      end else begin
        scan_step = 0;
        scan_pair = last_pair ? 0 : scan_pair + 1;
      end
    end
    return r;
  endfunction

  // channel value near the current pwm step, or an extreme, or anything
  function automatic logic [7:0] pick_channel();
    int v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 255;
      2: v = int'(scan_step) + $urandom_range(0, 2) - 1;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic send_item(req_type_t kind, logic [4:0] row, logic [5:0] column,
                           logic [23:0] color);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_idle_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    in_req_type     <= kind;
    in_pixel_row    <= row;
    in_pixel_column <= column;
    in_pixel_color  <= color;
    do @(posedge clk); while (full);
    beats_sent++;
    if (kind == REQ_TICK) pending_columns.push_back(advance_scan());
    else frame_mirror[row*COLUMNS + column] = color;
  endtask

  // pixel writes mostly land on the row pair and columns about to be shifted
  task automatic send_random_item(int tick_pct);
    int row;
    int column;
    if ($urandom_range(0, 99) < tick_pct) begin
      send_item(REQ_TICK, 5'($urandom), 6'($urandom), 24'($urandom));
    end else begin
      if ($urandom_range(0, 9) < 7) row = scan_pair + ($urandom_range(0, 1) ? PAIRS : 0);
      else row = $urandom_range(0, ROWS - 1);
      if ($urandom_range(0, 9) < 6) column = int'(scan_col) - $urandom_range(0, 7);
      else column = $urandom_range(0, COLUMNS - 1);
      if (column < 0) column = 0;
      send_item(REQ_PIXEL, 5'(row), 6'(column),
                {pick_channel(), pick_channel(), pick_channel()});
    end
  endtask

  // writes leave no result, so allow the pipeline to settle after the last one
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_pwm_depth(logic [3:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    depth_reg = value;
  endtask

  task automatic test_black_after_reset();
    repeat (3) send_item(REQ_TICK, '0, '0, '0);
  endtask

  task automatic test_pixel_extremes();
    int c;
    c = scan_col;
    send_item(REQ_PIXEL, 5'd0,  6'(c),     24'hFFFFFF);
    send_item(REQ_PIXEL, 5'd16, 6'(c),     24'h000000);
    send_item(REQ_PIXEL, 5'd0,  6'(c - 1), 24'h0000FF);
    send_item(REQ_PIXEL, 5'd16, 6'(c - 1), 24'h00FF00);
    send_item(REQ_PIXEL, 5'd0,  6'(c - 2), 24'hFF0000);
    send_item(REQ_PIXEL, 5'd16, 6'(c - 2), 24'h010101);
    send_item(REQ_PIXEL, 5'd0,  6'(c - 3), 24'h000001);
    send_item(REQ_PIXEL, 5'd16, 6'(c - 3), 24'hFFFFFF);
    send_item(REQ_PIXEL, 5'd31, 6'd63,     24'hFFFFFF);
    send_item(REQ_PIXEL, 5'd15, 6'd0,      24'h808080);
    repeat (4) send_item(REQ_TICK, 5'd31, 6'd63, 24'hFFFFFF);
  endtask

  // leave the scan several steps into a row pair, then shrink the depth under it
  task automatic test_depth_change_mid_scan();
    set_pwm_depth(DEPTH_BITS_MAX);
    repeat (200) send_random_item(90);
    set_pwm_depth(DEPTH_BITS_MIN);
    repeat (60) send_random_item(85);
  endtask

  // depth 0 acts as 1: two pwm steps per row pair
  task automatic test_depth_zero();
    set_pwm_depth(4'd0);
    repeat (100) send_random_item(95);
  endtask

  task automatic test_stall_fill();
    sender_idle_on = 1'b0;
    hold_request   = 1'b1;
    repeat (48) send_item(REQ_TICK, '0, '0, '0);
    sender_idle_on = 1'b1;
  endtask

  task automatic test_random_depths();
    logic [3:0] depths [5];
    depths = '{4'd15, 4'd2, 4'($urandom), 4'd9, 4'd1};
    foreach (depths[i]) begin
      set_pwm_depth(depths[i]);
      repeat (55) send_random_item(55);
    end
  endtask

  initial begin : result_sink
    int         hold_left;
    int         mode_left;
    int         period;
    int         cycle_count;
    sink_mode_t mode;
    result_t    want;
    hold_left   = 0;
    mode_left   = 0;
    period      = 2;
    cycle_count = 0;
    mode        = SINK_ALWAYS;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (pending_columns.size() == 0) begin
          $error("result beat with nothing expected");
          error_count++;
        end else begin
          want = pending_columns.pop_front();
          check_field("hub75_bits", want.hub75_bits, out_hub75_bits);
          check_field("row_address", want.row_address, out_row_address);
          check_field("shift_column", want.shift_column, out_shift_column);
          check_field("latch", want.latch, out_latch);
          check_field("frame_end", want.frame_end, out_frame_end);
          columns_checked++;
          if (want.frame_end) frames_seen++;
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 120;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 150);
        period    = $urandom_range(2, 9);
      end
      mode_left--;
      cycle_count++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          SINK_ALWAYS: pop <= 1'b1;
          SINK_RANDOM: pop <= ($urandom_range(0, 9) < 6);
          default:     pop <= ((cycle_count % period) <= period / 2);
        endcase
      end
    end
  end

  initial begin
    foreach (frame_mirror[i]) frame_mirror[i] = '0;
    scan_col  = COLUMNS - 1;
    scan_step = 0;
    scan_pair = 0;
    depth_reg = DEPTH_BITS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_black_after_reset();
    test_pixel_extremes();
    test_depth_change_mid_scan();
    test_stall_fill();
    test_depth_zero();
    test_random_depths();
    wait_idle();
    $display("covered %0d beats in, %0d scan columns checked, %0d frame ends seen",
             beats_sent, columns_checked, frames_seen);
    $display("pwm depths 0 to 15, mid-scan depth change, long result stall");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
